@@ hw/rtl/rtts_pkg.sv @@
package rtts_pkg;

  // Coordinate and field widths
  localparam int COORD_W = 16;
  localparam int WIDE_W  = COORD_W + 1;
  localparam int LOC_W   = 3;
  localparam int IDX_W   = 6;
  localparam int ROWS_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 5;

  // Largest span of tile columns and rows per query
  localparam int MAX_COLS = 8;
  localparam int MAX_ROWS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_ROWS  = 3'd4;

  // Result status codes
  localparam logic STATUS_TILE  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_y;
    logic [COORD_W-1:0] query_w;
    logic [COORD_W-1:0] query_h;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   tile_index;
    logic [LOC_W-1:0]   local_col;
    logic [LOC_W-1:0]   local_row;
    logic [COORD_W-1:0] sub_x;
    logic [COORD_W-1:0] sub_y;
    logic [COORD_W-1:0] sub_w;
    logic [COORD_W-1:0] sub_h;
    logic               last_tile;
  } out_word_t;

  // Corner divisions run one after another on the shared divider
  typedef enum logic [1:0] {
    OP_COL_FIRST = 2'd0,
    OP_ROW_FIRST = 2'd1,
    OP_COL_LAST  = 2'd2,
    OP_ROW_LAST  = 2'd3
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SPAN,
    ST_EMIT,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic    load_query;
    logic    div_start;
    div_op_t div_sel;
    div_op_t div_op;
    logic    init_walk;
    logic    emit_tile;
    logic    emit_error;
  } ctrl_cmd_t;

  typedef struct packed {
    logic qry_bad;
    logic span_bad;
    logic div_done;
    logic out_free;
    logic tile_last;
  } dp_status_t;

endpackage

@@ hw/rtl/rtts_div.sv @@
module rtts_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rtts_pkg::COORD_W-1:0]    dividend,
  input  logic [rtts_pkg::COORD_W-1:0]    divisor,
  output logic                            done,
  output logic [rtts_pkg::COORD_W-1:0]    quotient,
  output logic [rtts_pkg::COORD_W-1:0]    remainder
);

  logic                             active;
  logic [rtts_pkg::DIV_CNT_W-1:0]   cnt;
  logic [rtts_pkg::COORD_W-1:0]     dsr;
  logic [rtts_pkg::WIDE_W-1:0]      shifted;
  logic [rtts_pkg::WIDE_W-1:0]      trial;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {remainder, quotient[rtts_pkg::COORD_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= rtts_pkg::DIV_CNT_W'(rtts_pkg::COORD_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == rtts_pkg::DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Hold the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (active) begin
      if (!trial[rtts_pkg::WIDE_W-1]) begin
        remainder <= trial[rtts_pkg::COORD_W-1:0];
        quotient  <= {quotient[rtts_pkg::COORD_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[rtts_pkg::COORD_W-1:0];
        quotient  <= {quotient[rtts_pkg::COORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hw/rtl/rtts_datapath.sv @@
module rtts_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  rtts_pkg::ctrl_cmd_t              cmd,
  output rtts_pkg::dp_status_t             status,
  input  rtts_pkg::in_word_t               in_data,
  input  logic                             cfg_valid,
  input  logic [rtts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtts_pkg::COORD_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rtts_pkg::out_word_t              out_data
);

  localparam int CW = rtts_pkg::COORD_W;
  localparam int WW = rtts_pkg::WIDE_W;

  // Configuration
  logic [CW-1:0]               image_width, image_height, tile_width, tile_height;
  logic [rtts_pkg::ROWS_W-1:0] layout_rows;

  // Held query
  logic [CW-1:0] qx, qy, qw, qh;
  logic [WW-1:0] xe, ye;

  // Division results
  logic [CW-1:0] fc, fr, lc, lr, cs0, rs0;

  // Walk state
  logic [WW-1:0]                cs, cs_end, rs, rs_end, rs0_end;
  logic [rtts_pkg::LOC_W-1:0]   lcol, lrow, ncm1, nrm1;
  logic [rtts_pkg::IDX_W-1:0]   col_idx, row_idx;

  logic                  div_done;
  logic [CW-1:0]         div_q, div_r, div_a, div_b;
  logic [CW-1:0]         dc, dr;
  logic [9:0]            col_base;
  logic [WW-1:0]         left, right, top, bot;
  logic                  row_wrap;
  rtts_pkg::out_word_t   tile_word, err_word;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd2048;
      image_height <= 16'd2048;
      tile_width   <= 16'd256;
      tile_height  <= 16'd256;
      layout_rows  <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtts_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rtts_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        rtts_pkg::REG_TILE_WIDTH:   tile_width   <= cfg_data;
        rtts_pkg::REG_TILE_HEIGHT:  tile_height  <= cfg_data;
        rtts_pkg::REG_LAYOUT_ROWS:  layout_rows  <= cfg_data[rtts_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the query and its far edges
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx <= in_data.query_x;
      qy <= in_data.query_y;
      qw <= in_data.query_w;
      qh <= in_data.query_h;
      xe <= {1'b0, in_data.query_x} + {1'b0, in_data.query_w};
      ye <= {1'b0, in_data.query_y} + {1'b0, in_data.query_h};
    end
  end

  assign status.qry_bad = (qw == '0) || (qh == '0) || (tile_width == '0) ||
                          (tile_height == '0) || (xe > {1'b0, image_width}) ||
                          (ye > {1'b0, image_height});

  // Select operands of the next corner division
  always_comb begin
    case (cmd.div_sel)
      rtts_pkg::OP_COL_FIRST: begin div_a = qx;                    div_b = tile_width;  end
      rtts_pkg::OP_ROW_FIRST: begin div_a = qy;                    div_b = tile_height; end
      rtts_pkg::OP_COL_LAST:  begin div_a = CW'(xe - 1'b1);        div_b = tile_width;  end
      rtts_pkg::OP_ROW_LAST:  begin div_a = CW'(ye - 1'b1);        div_b = tile_height; end
      default:                begin div_a = qx;                    div_b = tile_width;  end
    endcase
  end

  rtts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign status.div_done = div_done;

  // Store first and last tile coordinates; first tiles also keep their origin
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_op)
        rtts_pkg::OP_COL_FIRST: begin fc <= div_q; cs0 <= qx - div_r; end
        rtts_pkg::OP_ROW_FIRST: begin fr <= div_q; rs0 <= qy - div_r; end
        rtts_pkg::OP_COL_LAST:  lc <= div_q;
        rtts_pkg::OP_ROW_LAST:  lr <= div_q;
        default: ;
      endcase
    end
  end

  // Span check; the tile count never exceeds MAX_COLS * MAX_ROWS once both pass
  assign dc = lc - fc;
  assign dr = lr - fr;
  assign status.span_bad = (dc > CW'(rtts_pkg::MAX_COLS - 1)) ||
                           (dr > CW'(rtts_pkg::MAX_ROWS - 1));

  assign col_base = {4'b0, fc[rtts_pkg::IDX_W-1:0]} * {6'b0, layout_rows};

  // Clip the query against the current tile
  always_comb begin
    left  = ({1'b0, qx} > cs) ? {1'b0, qx} : cs;
    right = (xe < cs_end) ? xe : cs_end;
    top   = ({1'b0, qy} > rs) ? {1'b0, qy} : rs;
    bot   = (ye < rs_end) ? ye : rs_end;
  end

  assign row_wrap         = (lrow == nrm1);
  assign status.tile_last = row_wrap && (lcol == ncm1);

  always_comb begin
    tile_word.status     = rtts_pkg::STATUS_TILE;
    tile_word.tile_index = col_idx + row_idx;
    tile_word.local_col  = lcol;
    tile_word.local_row  = lrow;
    tile_word.sub_x      = CW'(left - cs);
    tile_word.sub_y      = CW'(top - rs);
    tile_word.sub_w      = CW'(right - left);
    tile_word.sub_h      = CW'(bot - top);
    tile_word.last_tile  = status.tile_last;
    err_word             = '0;
    err_word.status      = rtts_pkg::STATUS_ERROR;
    err_word.last_tile   = 1'b1;
  end

  // Advance the walk: rows inner, columns outer
  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      cs      <= {1'b0, cs0};
      cs_end  <= {1'b0, cs0} + {1'b0, tile_width};
      rs      <= {1'b0, rs0};
      rs_end  <= {1'b0, rs0} + {1'b0, tile_height};
      rs0_end <= {1'b0, rs0} + {1'b0, tile_height};
      lcol    <= '0;
      lrow    <= '0;
      ncm1    <= dc[rtts_pkg::LOC_W-1:0];
      nrm1    <= dr[rtts_pkg::LOC_W-1:0];
      col_idx <= col_base[rtts_pkg::IDX_W-1:0];
      row_idx <= fr[rtts_pkg::IDX_W-1:0];
    end else if (cmd.emit_tile) begin
      if (row_wrap) begin
        rs      <= {1'b0, rs0};
        rs_end  <= rs0_end;
        lrow    <= '0;
        row_idx <= fr[rtts_pkg::IDX_W-1:0];
        cs      <= cs_end;
        cs_end  <= cs_end + {1'b0, tile_width};
        lcol    <= lcol + 1'b1;
        col_idx <= col_idx + {2'b0, layout_rows};
      end else begin
        rs      <= rs_end;
        rs_end  <= rs_end + {1'b0, tile_height};
        lrow    <= lrow + 1'b1;
        row_idx <= row_idx + 1'b1;
      end
    end
  end

  // Output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_tile || cmd.emit_error) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tile) begin
      out_data <= tile_word;
    end else if (cmd.emit_error) begin
      out_data <= err_word;
    end
  end

endmodule

@@ hw/rtl/rtts_ctrl.sv @@
module rtts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output rtts_pkg::ctrl_cmd_t   cmd,
  input  rtts_pkg::dp_status_t  status
);

  rtts_pkg::state_t  state, state_next;
  rtts_pkg::div_op_t op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtts_pkg::ST_IDLE;
      op    <= rtts_pkg::OP_COL_FIRST;
    end else begin
      state <= state_next;
      if (state == rtts_pkg::ST_CHECK) begin
        op <= rtts_pkg::OP_COL_FIRST;
      end else if (state == rtts_pkg::ST_DIV && status.div_done) begin
        op <= rtts_pkg::div_op_t'(op + 1'b1);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rtts_pkg::ST_IDLE:
        if (in_valid) state_next = rtts_pkg::ST_CHECK;
      rtts_pkg::ST_CHECK:
        state_next = status.qry_bad ? rtts_pkg::ST_ERROR : rtts_pkg::ST_DIV;
      rtts_pkg::ST_DIV:
        if (status.div_done && op == rtts_pkg::OP_ROW_LAST) state_next = rtts_pkg::ST_SPAN;
      rtts_pkg::ST_SPAN:
        state_next = status.span_bad ? rtts_pkg::ST_ERROR : rtts_pkg::ST_EMIT;
      rtts_pkg::ST_EMIT:
        if (status.out_free && status.tile_last) state_next = rtts_pkg::ST_IDLE;
      rtts_pkg::ST_ERROR:
        if (status.out_free) state_next = rtts_pkg::ST_IDLE;
      default:
        state_next = rtts_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.div_sel    = rtts_pkg::OP_COL_FIRST;
    cmd.div_op     = op;
    case (state)
      rtts_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_query = in_valid;
      end
      rtts_pkg::ST_CHECK: begin
        cmd.div_start = !status.qry_bad;
      end
      rtts_pkg::ST_DIV: begin
        if (status.div_done && op != rtts_pkg::OP_ROW_LAST) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = rtts_pkg::div_op_t'(op + 1'b1);
        end
      end
      rtts_pkg::ST_SPAN:  cmd.init_walk  = !status.span_bad;
      rtts_pkg::ST_EMIT:  cmd.emit_tile  = status.out_free;
      rtts_pkg::ST_ERROR: cmd.emit_error = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/region_to_tile_splitter.sv @@
// A valid query's first word waits on the four corner divisions, which run one after
// another on one bit-serial divider. Tile words then leave one per cycle while the
// output is not stalled; a query holds the block until its last word is registered.
// An empty or overrunning extent gives its error word before any division starts,
// a span too wide for the walk only after all four. Reset (rst, synchronous, active high)
// idles the controller, empties the output register and loads config defaults.
module region_to_tile_splitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rtts_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rtts_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtts_pkg::COORD_W-1:0]     cfg_data
);

  rtts_pkg::ctrl_cmd_t  cmd;
  rtts_pkg::dp_status_t status;

  // Configuration writes are taken in any cycle
  assign cfg_ready = 1'b1;

  rtts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  rtts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb_top.sv @@
module tb_top;

  localparam int NUM_REGS     = 5;
  localparam int NUM_SETTINGS = 11;
  localparam int NUM_MODES    = 4;
  localparam int ITEMS_PER_MODE = 10;
  localparam int SETTLE_CYCLES  = 8;

  // Expected tile words per query, built from a mirror of the configuration
  class tile_scoreboard;
    rtts_pkg::out_word_t tiles_due[$];
    logic [rtts_pkg::COORD_W-1:0] img_w, img_h, tl_w, tl_h;
    logic [rtts_pkg::ROWS_W-1:0]  rows;
    int errors;

    function new();
      img_w  = 16'd2048;
      img_h  = 16'd2048;
      tl_w   = 16'd256;
      tl_h   = 16'd256;
      rows   = 4'd8;
      errors = 0;
    endfunction

    function void set_reg(logic [rtts_pkg::CFG_IDX_W-1:0] idx,
                          logic [rtts_pkg::COORD_W-1:0] val);
      case (idx)
        rtts_pkg::REG_IMAGE_WIDTH:  img_w = val;
        rtts_pkg::REG_IMAGE_HEIGHT: img_h = val;
        rtts_pkg::REG_TILE_WIDTH:   tl_w = val;
        rtts_pkg::REG_TILE_HEIGHT:  tl_h = val;
        rtts_pkg::REG_LAYOUT_ROWS:  rows = val[rtts_pkg::ROWS_W-1:0];
        default: ;
      endcase
    endfunction

    // Split one accepted query into the tile words it must produce
    function void add_query_tiles(rtts_pkg::in_word_t q);
      int unsigned x, y, w, h, fc, fr, lc, lr, c, r, cs, rs, lft, rgt, top, bot;
      bit bad;
      rtts_pkg::out_word_t e;
      x = q.query_x;
      y = q.query_y;
      w = q.query_w;
      h = q.query_h;
      e = '0;
      bad = (w == 0) || (h == 0) || (tl_w == 0) || (tl_h == 0) ||
            (x + w > img_w) || (y + h > img_h);
      if (!bad) begin
        fc = x / tl_w;
        fr = y / tl_h;
        lc = (x + w - 1) / tl_w;
        lr = (y + h - 1) / tl_h;
        bad = (lc - fc >= rtts_pkg::MAX_COLS) || (lr - fr >= rtts_pkg::MAX_ROWS);
      end
      // Rejected extent: a single error word with every other field clear
      if (bad) begin
        e.status    = rtts_pkg::STATUS_ERROR;
        e.last_tile = 1'b1;
        tiles_due.push_back(e);
        return;
      end
      // Walk columns outside, rows inside; the last tile holds the last pixel
      for (c = fc; c <= lc; c++) begin
        cs  = c * tl_w;
        lft = (x > cs) ? x : cs;
        rgt = (x + w < cs + tl_w) ? x + w : cs + tl_w;
        for (r = fr; r <= lr; r++) begin
          rs  = r * tl_h;
          top = (y > rs) ? y : rs;
          bot = (y + h < rs + tl_h) ? y + h : rs + tl_h;
          e.status     = rtts_pkg::STATUS_TILE;
          e.tile_index = rtts_pkg::IDX_W'(c * rows + r);
          e.local_col  = rtts_pkg::LOC_W'(c - fc);
          e.local_row  = rtts_pkg::LOC_W'(r - fr);
          e.sub_x      = rtts_pkg::COORD_W'(lft - cs);
          e.sub_y      = rtts_pkg::COORD_W'(top - rs);
          e.sub_w      = rtts_pkg::COORD_W'(rgt - lft);
          e.sub_h      = rtts_pkg::COORD_W'(bot - top);
          e.last_tile  = (c == lc) && (r == lr);
          tiles_due.push_back(e);
        end
      end
    endfunction

    function int field_diff(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, seen);
        return 1;
      end
      return 0;
    endfunction

    // Compare one output word against the oldest expected tile
    function void check_tile_word(rtts_pkg::out_word_t got);
      rtts_pkg::out_word_t e;
      int bad_fields;
      if (tiles_due.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = tiles_due.pop_front();
      bad_fields = field_diff("status", e.status, got.status) +
                   field_diff("tile_index", e.tile_index, got.tile_index) +
                   field_diff("local_col", e.local_col, got.local_col) +
                   field_diff("local_row", e.local_row, got.local_row) +
                   field_diff("sub_x", e.sub_x, got.sub_x) +
                   field_diff("sub_y", e.sub_y, got.sub_y) +
                   field_diff("sub_w", e.sub_w, got.sub_w) +
                   field_diff("sub_h", e.sub_h, got.sub_h) +
                   field_diff("last_tile", e.last_tile, got.last_tile);
      if (bad_fields != 0) errors++;
    endfunction

    function int pending();
      return tiles_due.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  rtts_pkg::in_word_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rtts_pkg::out_word_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rtts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rtts_pkg::COORD_W-1:0]   cfg_data = '0;

  tile_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_pct_by_mode [NUM_MODES] = '{0, 51, 0, 19};
  int unsigned recv_pct_by_mode [NUM_MODES] = '{0, 0, 51, 19};

  logic [rtts_pkg::CFG_IDX_W-1:0] reg_order [NUM_REGS] = '{
      rtts_pkg::REG_IMAGE_WIDTH, rtts_pkg::REG_IMAGE_HEIGHT,
      rtts_pkg::REG_TILE_WIDTH, rtts_pkg::REG_TILE_HEIGHT,
      rtts_pkg::REG_LAYOUT_ROWS};

  // Image width, image height, tile width, tile height, layout rows
  int unsigned phase_regs [NUM_SETTINGS][NUM_REGS] = '{
    '{2048, 2048, 256, 256, 8},
    '{64, 64, 8, 8, 8},
    '{65535, 65535, 1, 1, 15},
    '{65535, 65535, 65535, 65535, 0},
    '{100, 50, 7, 13, 9},
    '{1, 1, 1, 1, 1},
    '{300, 200, 0, 40, 3},
    '{300, 200, 40, 0, 5},
    '{0, 500, 60, 70, 12},
    '{40000, 0, 5000, 9000, 7},
    '{65535, 40000, 8192, 5000, 6}
  };

  // Corners, whole image, tile edges, empty and overrunning extents
  rtts_pkg::in_word_t directed_q [$] = '{
    '{16'd0, 16'd0, 16'd1, 16'd1},
    '{16'd2047, 16'd2047, 16'd1, 16'd1},
    '{16'd0, 16'd0, 16'd2048, 16'd2048},
    '{16'd255, 16'd255, 16'd2, 16'd2},
    '{16'd256, 16'd512, 16'd256, 16'd256},
    '{16'd0, 16'd1000, 16'd2048, 16'd1},
    '{16'd1000, 16'd0, 16'd1, 16'd2048},
    '{16'd300, 16'd700, 16'd1500, 16'd900},
    '{16'd5, 16'd5, 16'd0, 16'd10},
    '{16'd5, 16'd5, 16'd10, 16'd0},
    '{16'd1, 16'd0, 16'd2048, 16'd1},
    '{16'd0, 16'd2047, 16'd1, 16'd2},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd0, 16'd0, 16'd0, 16'd0}
  };

  region_to_tile_splitter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check each accepted word, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_tile_word(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Pick a span that fits a nonzero image, no longer than one or nine tiles
  function automatic void pick_span(input int unsigned img, input int unsigned tile,
                                    output int unsigned pos, output int unsigned len);
    int unsigned top;
    if (img == 0) begin
      pos = $urandom_range(65535);
      len = $urandom_range(65535, 1);
      return;
    end
    top = (tile == 0) ? img : tile * (($urandom_range(2) == 0) ? 1 : 9);
    if (top > img) top = img;
    len = $urandom_range(top, 1);
    pos = $urandom_range(img - len, 0);
  endfunction

  // Mostly in-bounds queries, some noise, some empty or overrunning ones
  function automatic rtts_pkg::in_word_t random_query();
    int unsigned roll, x, y, w, h;
    roll = $urandom_range(99);
    pick_span(sb.img_w, sb.tl_w, x, w);
    pick_span(sb.img_h, sb.tl_h, y, h);
    if (roll >= 90) begin
      x = $urandom_range(65535);
      y = $urandom_range(65535);
      w = $urandom_range(65535);
      h = $urandom_range(65535);
    end else if (roll >= 80) begin
      case ($urandom_range(3))
        0: w = 0;
        1: h = 0;
        2: if (sb.img_w != 0) begin
          w = $urandom_range(sb.img_w, 1);
          x = sb.img_w - w + 1;
        end
        default: if (sb.img_h != 0) begin
          h = $urandom_range(sb.img_h, 1);
          y = sb.img_h - h + 1;
        end
      endcase
    end
    return '{rtts_pkg::COORD_W'(x), rtts_pkg::COORD_W'(y),
             rtts_pkg::COORD_W'(w), rtts_pkg::COORD_W'(h)};
  endfunction

  // Offer one query word, idling first at random; hold it until taken
  task automatic send_query(input rtts_pkg::in_word_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    sb.add_query_tiles(q);
  endtask

  // Write all registers of one setting plus an unmapped index
  task automatic write_settings(input int unsigned p);
    int i;
    logic [rtts_pkg::CFG_IDX_W-1:0] idx;
    logic [rtts_pkg::COORD_W-1:0]   val;
    for (i = 0; i <= NUM_REGS; i++) begin
      if (i < NUM_REGS) begin
        idx = reg_order[i];
        val = rtts_pkg::COORD_W'(phase_regs[p][i]);
        if (idx == rtts_pkg::REG_LAYOUT_ROWS) begin
          val = val | rtts_pkg::COORD_W'($urandom_range(4095) << rtts_pkg::ROWS_W);
        end
      end else begin
        idx = rtts_pkg::CFG_IDX_W'(rtts_pkg::REG_LAYOUT_ROWS + 1 + $urandom_range(2));
        val = rtts_pkg::COORD_W'($urandom_range(65535));
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx, val);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected word, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned p, k, mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_q[i]) send_query(directed_q[i]);
    for (p = 0; p < NUM_SETTINGS; p++) begin
      if (p != 0) write_settings(p);
      for (mode = 0; mode < NUM_MODES; mode++) begin
        send_idle_pct  = send_pct_by_mode[mode];
        recv_stall_pct = recv_pct_by_mode[mode];
        for (k = 0; k < ITEMS_PER_MODE; k++) send_query(random_query());
      end
      in_valid <= 1'b0;
      drain();
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
